### hdl/c2s_pkg.sv
// Shared constants for the Cartesian-to-spherical conversion pipeline.
package c2s_pkg;

	localparam int ANGLE_Q   = 32;
	localparam int NORM_TOP  = 59;
	localparam int NORM_W    = NORM_TOP + 1;
	localparam int CORD_W    = 64;
	localparam int ZACC_W    = 36;
	localparam int MAX_STEPS = 32;

	localparam logic signed [ZACC_W-1:0] PI_Q32 = 36'sd13493037705;

	localparam logic signed [ZACC_W-1:0] ATAN_Q32 [MAX_STEPS] = '{
		36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
		36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
		36'sd16777131,   36'sd8388597,    36'sd4194303,    36'sd2097152,
		36'sd1048576,    36'sd524288,     36'sd262144,     36'sd131072,
		36'sd65536,      36'sd32768,      36'sd16384,      36'sd8192,
		36'sd4096,       36'sd2048,       36'sd1024,       36'sd512,
		36'sd256,        36'sd128,        36'sd64,         36'sd32,
		36'sd16,         36'sd8,          36'sd4,          36'sd2
	};

endpackage

### hdl/cartesian_to_spherical_unit.sv
// Pipelined conversion of a point difference into radius, azimuth and polar angle.
// Throughput is one item per cycle; the whole pipeline freezes only while the output is stalled.
// The depth is set by the 61 one-bit steps of the planar square root feeding the polar CORDIC.
// Reset clears all valid bits asynchronously; data registers are not reset.
module cartesian_to_spherical_unit #(
	parameter int COORD_WIDTH  = 32,
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z from the lowest bit up.
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// radius, azimuth, polar_angle from the lowest bit up.
	output logic [((COORD_WIDTH+2*FRAC_BITS+6+7)/8)*8-1:0] m_tdata,
	// degenerate.
	output logic m_tuser
);

	localparam int CW    = COORD_WIDTH;
	localparam int DW    = CW + 1;
	localparam int MW    = CW + 1;
	localparam int SQW   = 2 * MW;
	localparam int RS    = MW + 1;
	localparam int RW    = 2 * RS;
	localparam int QS    = c2s_pkg::NORM_W + 1;
	localparam int QW    = 2 * QS;
	localparam int KW    = $clog2(c2s_pkg::NORM_TOP + 1);
	localparam int MSBW  = $clog2(MW);
	localparam int CI    = (CORDIC_STEPS > c2s_pkg::MAX_STEPS) ? c2s_pkg::MAX_STEPS
		: CORDIC_STEPS;
	localparam int L     = QS + 1 + CI;
	localparam int IN_W  = ((6*CW+7)/8)*8;
	localparam int OUT_F = CW + 1 + 2*FRAC_BITS + 5;
	localparam int OUT_W = ((OUT_F+7)/8)*8;
	localparam int AW    = FRAC_BITS + 3;
	localparam int PW    = FRAC_BITS + 2;
	localparam int ASH   = c2s_pkg::ANGLE_Q - FRAC_BITS;
	localparam int XW    = c2s_pkg::CORD_W;
	localparam int ZW    = c2s_pkg::ZACC_W;
	localparam logic signed [ZW-1:0] LIM  = c2s_pkg::PI_Q32 >>> ASH;
	localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (ASH - 1);

	typedef struct packed {
		logic                 valid;
		logic                 deg;
		logic                 xy_zero;
		logic                 dz_neg;
		logic [RW-1:0]        r_op;
		logic [RS-1:0]        r_root;
		logic [RS+1:0]        r_rem;
		logic [QW-1:0]        q_op;
		logic [QS-1:0]        q_root;
		logic [QS+1:0]        q_rem;
		logic signed [XW-1:0] a_x;
		logic signed [XW-1:0] a_y;
		logic signed [ZW-1:0] a_z;
		logic signed [XW-1:0] p_x;
		logic signed [XW-1:0] p_y;
		logic signed [ZW-1:0] p_z;
	} work_t;

	logic en;
	logic out_valid_q;

	// Stage 1: differences.
	logic                 valid_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;

	// Stage 2: magnitudes and signs.
	logic          valid_s2, deg_s2, xn_s2, yn_s2, zn_s2;
	logic [MW-1:0] ax_s2, ay_s2, az_s2;

	// Stage 3: squares and the largest magnitude.
	logic           valid_s3, deg_s3, xn_s3, yn_s3, zn_s3, xyz_s3;
	logic [MW-1:0]  ax_s3, ay_s3, az_s3, m_s3;
	logic [SQW-1:0] sqx_s3, sqy_s3, sqz_s3;

	// Stage 4: sums and the normalizing shift.
	logic           valid_s4, deg_s4, xn_s4, yn_s4, zn_s4, xyz_s4;
	logic [MW-1:0]  ax_s4, ay_s4, az_s4;
	logic [RW-1:0]  sum_s4;
	logic [SQW:0]   q_s4;
	logic [KW-1:0]  k_s4;

	logic [MSBW-1:0] msb;
	logic [KW-1:0]   k_next;

	work_t work_s [0:L];
	work_t init;

	logic [RS-1:0]        rad_rnd;
	logic signed [ZW-1:0] az_v, po_v, az_c, po_c;

	logic [CW:0]   rad_q;
	logic [AW-1:0] azi_q;
	logic [PW-1:0] pol_q;
	logic          deg_q;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({s_tdata[4*CW-1], s_tdata[4*CW-1:3*CW]})
				- $signed({s_tdata[CW-1], s_tdata[CW-1:0]});
			dy_s1 <= $signed({s_tdata[5*CW-1], s_tdata[5*CW-1:4*CW]})
				- $signed({s_tdata[2*CW-1], s_tdata[2*CW-1:CW]});
			dz_s1 <= $signed({s_tdata[6*CW-1], s_tdata[6*CW-1:5*CW]})
				- $signed({s_tdata[3*CW-1], s_tdata[3*CW-1:2*CW]});

			xn_s2  <= dx_s1[DW-1];
			yn_s2  <= dy_s1[DW-1];
			zn_s2  <= dz_s1[DW-1];
			ax_s2  <= dx_s1[DW-1] ? MW'(-dx_s1) : MW'(dx_s1);
			ay_s2  <= dy_s1[DW-1] ? MW'(-dy_s1) : MW'(dy_s1);
			az_s2  <= dz_s1[DW-1] ? MW'(-dz_s1) : MW'(dz_s1);
			deg_s2 <= (dx_s1 == '0) && (dy_s1 == '0) && (dz_s1 == '0);

			{deg_s3, xn_s3, yn_s3, zn_s3} <= {deg_s2, xn_s2, yn_s2, zn_s2};
			{ax_s3, ay_s3, az_s3}         <= {ax_s2, ay_s2, az_s2};
			xyz_s3 <= (ax_s2 == '0) && (ay_s2 == '0);
			sqx_s3 <= SQW'(ax_s2) * SQW'(ax_s2);
			sqy_s3 <= SQW'(ay_s2) * SQW'(ay_s2);
			sqz_s3 <= SQW'(az_s2) * SQW'(az_s2);
			if (ax_s2 >= ay_s2 && ax_s2 >= az_s2) begin
				m_s3 <= ax_s2;
			end else if (ay_s2 >= az_s2) begin
				m_s3 <= ay_s2;
			end else begin
				m_s3 <= az_s2;
			end

			{deg_s4, xn_s4, yn_s4, zn_s4, xyz_s4} <= {deg_s3, xn_s3, yn_s3, zn_s3, xyz_s3};
			{ax_s4, ay_s4, az_s4} <= {ax_s3, ay_s3, az_s3};
			sum_s4 <= RW'(sqx_s3) + RW'(sqy_s3) + RW'(sqz_s3);
			q_s4   <= (SQW+1)'(sqx_s3) + (SQW+1)'(sqy_s3);
			k_s4   <= k_next;
		end
	end

	always_comb begin
		msb = '0;
		for (int b = 0; b < MW; b++) begin
			if (m_s3[b]) begin
				msb = MSBW'(b);
			end
		end
		k_next = KW'(c2s_pkg::NORM_TOP) - KW'(msb);
	end

	// Stage 5: normalize and set up the square roots and the azimuth rotation.
	always_comb begin
		logic [c2s_pkg::NORM_W-1:0] sx, sy, sz;
		logic signed [XW-1:0]       ys;
		sx = c2s_pkg::NORM_W'(ax_s4) << k_s4;
		sy = c2s_pkg::NORM_W'(ay_s4) << k_s4;
		sz = c2s_pkg::NORM_W'(az_s4) << k_s4;
		ys = yn_s4 ? -$signed(XW'(sy)) : $signed(XW'(sy));
		init         = '0;
		init.valid   = valid_s4;
		init.deg     = deg_s4;
		init.xy_zero = xyz_s4;
		init.dz_neg  = zn_s4;
		init.r_op    = sum_s4;
		init.q_op    = QW'(q_s4) << {k_s4, 1'b0};
		init.a_x     = $signed(XW'(sx));
		init.p_x     = $signed(XW'(sz));
		if (xn_s4) begin
			init.a_z = yn_s4 ? -c2s_pkg::PI_Q32 : c2s_pkg::PI_Q32;
			init.a_y = -ys;
		end else begin
			init.a_z = '0;
			init.a_y = ys;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_s[0].valid <= 1'b0;
		end else if (en) begin
			work_s[0] <= init;
		end
	end

	for (genvar j = 0; j < L; j++) begin : g_step
		localparam int AI = (j < CI) ? j : 0;
		localparam int PI_IDX = (j > QS && j <= QS + CI) ? j - QS - 1 : 0;
		work_t nx;

		always_comb begin
			logic [RS+3:0]        rt, rtr;
			logic [QS+3:0]        qt, qtr;
			logic signed [XW-1:0] xs, ys, rxy;
			nx = work_s[j];
			rt = '0;
			rtr = '0;
			qt = '0;
			qtr = '0;
			xs = '0;
			ys = '0;
			rxy = $signed(XW'(work_s[j].q_root));
			if (j < RS) begin
				rt = {work_s[j].r_rem, work_s[j].r_op[RW-1 -: 2]};
				rtr = {2'b00, work_s[j].r_root, 2'b01};
				nx.r_op = work_s[j].r_op << 2;
				if (rt >= rtr) begin
					nx.r_rem  = (RS+2)'(rt - rtr);
					nx.r_root = {work_s[j].r_root[RS-2:0], 1'b1};
				end else begin
					nx.r_rem  = rt[RS+1:0];
					nx.r_root = {work_s[j].r_root[RS-2:0], 1'b0};
				end
			end
			if (j < QS) begin
				qt = {work_s[j].q_rem, work_s[j].q_op[QW-1 -: 2]};
				qtr = {2'b00, work_s[j].q_root, 2'b01};
				nx.q_op = work_s[j].q_op << 2;
				if (qt >= qtr) begin
					nx.q_rem  = (QS+2)'(qt - qtr);
					nx.q_root = {work_s[j].q_root[QS-2:0], 1'b1};
				end else begin
					nx.q_rem  = qt[QS+1:0];
					nx.q_root = {work_s[j].q_root[QS-2:0], 1'b0};
				end
			end
			if (j < CI) begin
				xs = work_s[j].a_x >>> AI;
				ys = work_s[j].a_y >>> AI;
				if (!work_s[j].a_y[XW-1]) begin
					nx.a_x = work_s[j].a_x + ys;
					nx.a_y = work_s[j].a_y - xs;
					nx.a_z = work_s[j].a_z + c2s_pkg::ATAN_Q32[AI];
				end else begin
					nx.a_x = work_s[j].a_x - ys;
					nx.a_y = work_s[j].a_y + xs;
					nx.a_z = work_s[j].a_z - c2s_pkg::ATAN_Q32[AI];
				end
			end
			if (j == QS) begin
				if (work_s[j].dz_neg) begin
					nx.p_z = c2s_pkg::PI_Q32;
					nx.p_y = -rxy;
				end else begin
					nx.p_z = '0;
					nx.p_y = rxy;
				end
			end
			if (j > QS && j <= QS + CI) begin
				xs = work_s[j].p_x >>> PI_IDX;
				ys = work_s[j].p_y >>> PI_IDX;
				if (!work_s[j].p_y[XW-1]) begin
					nx.p_x = work_s[j].p_x + ys;
					nx.p_y = work_s[j].p_y - xs;
					nx.p_z = work_s[j].p_z + c2s_pkg::ATAN_Q32[PI_IDX];
				end else begin
					nx.p_x = work_s[j].p_x - ys;
					nx.p_y = work_s[j].p_y + xs;
					nx.p_z = work_s[j].p_z - c2s_pkg::ATAN_Q32[PI_IDX];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				work_s[j+1].valid <= 1'b0;
			end else if (en) begin
				work_s[j+1] <= nx;
			end
		end
	end

	// Output stage: round the radius and the angles, clamp the angles to pi.
	always_comb begin
		rad_rnd = work_s[L].r_root
			+ RS'(work_s[L].r_rem > {2'b00, work_s[L].r_root});
		az_v = (work_s[L].a_z + HALF) >>> ASH;
		po_v = (work_s[L].p_z + HALF) >>> ASH;
		if (az_v > LIM) begin
			az_c = LIM;
		end else if (az_v < -LIM) begin
			az_c = -LIM;
		end else begin
			az_c = az_v;
		end
		if (po_v > LIM) begin
			po_c = LIM;
		end else if (po_v < 0) begin
			po_c = '0;
		end else begin
			po_c = po_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= work_s[L].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_q <= work_s[L].deg;
			if (work_s[L].deg) begin
				rad_q <= '0;
				azi_q <= '0;
				pol_q <= '0;
			end else begin
				rad_q <= rad_rnd[CW:0];
				azi_q <= work_s[L].xy_zero ? '0 : az_c[AW-1:0];
				pol_q <= po_c[PW-1:0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({pol_q, azi_q, rad_q});
	assign m_tuser  = deg_q;

endmodule

### hdl/c2s_checker.sv
// Port-level checker for the Cartesian-to-spherical unit and its bind statement.
module c2s_checker #(
	parameter int COORD_WIDTH  = 32,
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((COORD_WIDTH+2*FRAC_BITS+6+7)/8)*8-1:0] m_tdata,
	input logic m_tuser
);

	localparam int AW  = FRAC_BITS + 3;
	localparam int PW  = FRAC_BITS + 2;
	localparam int AL  = COORD_WIDTH + 1;
	localparam int PL  = AL + AW;
	localparam int SW  = (CORDIC_STEPS > 0) ? c2s_pkg::ZACC_W : c2s_pkg::ZACC_W;
	localparam logic signed [SW-1:0] LIM =
		c2s_pkg::PI_Q32 >>> (c2s_pkg::ANGLE_Q - FRAC_BITS);

	logic signed [AW-1:0] azimuth;
	logic [PW-1:0]        polar;

	assign azimuth = $signed(m_tdata[PL-1:AL]);
	assign polar   = m_tdata[PL+PW-1:PL];

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
	else $error("Input ready does not follow the output register state.");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("Stalled output item changed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
	else $error("Degenerate item carries nonzero data.");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> azimuth <= LIM && azimuth >= -LIM && $signed({1'b0, polar}) <= LIM)
	else $error("Output angle outside the range of pi.");

	assert property (@(posedge clk) $rose(arst_n) |-> !m_tvalid)
	else $error("Output valid after reset.");

endmodule

bind cartesian_to_spherical_unit c2s_checker #(
	.COORD_WIDTH(COORD_WIDTH),
	.FRAC_BITS(FRAC_BITS),
	.CORDIC_STEPS(CORDIC_STEPS)
) u_c2s_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for the Cartesian-to-spherical conversion unit.
module tb_top;

	localparam int CW    = 32;
	localparam int FB    = 16;
	localparam int STEPS = 24;
	localparam int WDOG  = 3000;

	typedef logic [5:0][CW-1:0] pair_t;

	typedef struct {
		logic [CW:0]     radius;
		logic [FB+2:0]   azimuth;
		logic [FB+1:0]   polar;
		logic            degen;
	} sph_t;

	function automatic logic [63:0] root_floor(logic [127:0] s);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= s) r = c;
		end
		return r;
	endfunction

	function automatic longint cordic_angle(longint x, longint y);
		longint z;
		longint xs;
		longint ys;
		longint step;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(c2s_pkg::PI_Q32) : -longint'(c2s_pkg::PI_Q32);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS && i < c2s_pkg::MAX_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			step = longint'(c2s_pkg::ATAN_Q32[i]);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += step;
			end else begin
				x = x - ys; y = y + xs; z -= step;
			end
		end
		return z;
	endfunction

	function automatic longint round_angle(longint zq);
		longint lim;
		longint v;
		lim = longint'(c2s_pkg::PI_Q32) >>> (c2s_pkg::ANGLE_Q - FB);
		v = (zq + (64'sd1 <<< (c2s_pkg::ANGLE_Q - FB - 1))) >>> (c2s_pkg::ANGLE_Q - FB);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v;
	endfunction

	function automatic sph_t convert(pair_t p);
		sph_t o;
		longint dx, dy, dz, az_q, po_q, pa;
		logic [63:0] ax, ay, az, m, r, sx, sy, sz, rxy;
		logic [127:0] s;
		int k;
		dx = longint'(signed'(p[3])) - longint'(signed'(p[0]));
		dy = longint'(signed'(p[4])) - longint'(signed'(p[1]));
		dz = longint'(signed'(p[5])) - longint'(signed'(p[2]));
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		az = dz < 0 ? -dz : dz;
		o = '{0, 0, 0, 0};
		if (ax == 0 && ay == 0 && az == 0) begin
			o.degen = 1;
			return o;
		end
		s = {64'd0, ax} * ax + {64'd0, ay} * ay + {64'd0, az} * az;
		r = root_floor(s);
		if (s > {64'd0, r} * r + r) r++;
		m = ax;
		if (ay > m) m = ay;
		if (az > m) m = az;
		k = 0;
		while (((m << k) >> c2s_pkg::NORM_TOP) == 0) k++;
		sx = ax << k; sy = ay << k; sz = az << k;
		az_q = 0;
		if (ax != 0 || ay != 0)
			az_q = cordic_angle(dx < 0 ? -longint'(sx) : longint'(sx),
				dy < 0 ? -longint'(sy) : longint'(sy));
		rxy = root_floor({64'd0, sx} * sx + {64'd0, sy} * sy);
		po_q = cordic_angle(dz < 0 ? -longint'(sz) : longint'(sz), longint'(rxy));
		o.radius = r[CW:0];
		o.azimuth = (FB+3)'(round_angle(az_q));
		pa = round_angle(po_q);
		if (pa < 0) pa = 0;
		o.polar = (FB+2)'(pa);
		return o;
	endfunction

	class sph_board;
		sph_t pending[$];
		int   errors;

		function void note(pair_t p);
			pending = {pending, convert(p)};
		endfunction

		function void check(logic [71:0] d, logic u);
			sph_t e;
			if (pending.size() == 0) begin
				$error("result item with no item pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[CW:0] !== e.radius) begin
				$error("radius expected %0d actual %0d", e.radius, d[CW:0]);
				errors++;
			end
			if (d[CW+FB+3:CW+1] !== e.azimuth) begin
				$error("azimuth expected %0d actual %0d",
					signed'(e.azimuth), signed'(d[CW+FB+3:CW+1]));
				errors++;
			end
			if (d[CW+2*FB+5:CW+FB+4] !== e.polar) begin
				$error("polar_angle expected %0d actual %0d", e.polar, d[CW+2*FB+5:CW+FB+4]);
				errors++;
			end
			if (u !== e.degen) begin
				$error("degenerate expected %0d actual %0d", e.degen, u);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [191:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [71:0] m_tdata;
	logic m_tuser;

	sph_board board = new();
	int  idle_cycles = 0;
	bit  hold_req = 0;

	cartesian_to_spherical_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial forever #4 clk = ~clk;

	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check(m_tdata, m_tuser);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles = 0;
		else if (arst_n) idle_cycles++;
		if (idle_cycles >= WDOG) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_pair(pair_t p, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= p;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note(p);
	endtask

	function automatic logic [CW-1:0] coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 255) - 128;
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 0;
		endcase
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) p[i] = coord(kind < 5 ? 0 : $urandom_range(0, 2));
		for (int i = 3; i < 6; i++) begin
			case (kind)
				5: p[i] = p[i-3];
				6: p[i] = p[i-3] + coord(1);
				7: p[i] = $urandom_range(0, 1) ? p[i-3] : coord(0);
				default: p[i] = coord(kind < 5 ? 0 : $urandom_range(0, 3));
			endcase
		end
		return p;
	endfunction

	initial begin
		int gap;
		forever begin
			if (hold_req) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		pair_t dir[$];
		pair_t p;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		p = '0; dir = {dir, p};
		p = '0; p[0] = 32'h80000000; p[1] = 32'h80000000; p[2] = 32'h80000000;
		p[3] = 32'h7fffffff; p[4] = 32'h7fffffff; p[5] = 32'h7fffffff; dir = {dir, p};
		p = '0; p[0] = 32'h7fffffff; p[1] = 32'h7fffffff; p[2] = 32'h7fffffff;
		p[3] = 32'h80000000; p[4] = 32'h80000000; p[5] = 32'h80000000; dir = {dir, p};
		p = '0; p[5] = 32'h00010000; dir = {dir, p};
		p = '0; p[5] = 32'hffff0000; dir = {dir, p};
		p = '0; p[5] = 32'h80000000; dir = {dir, p};
		p = '0; p[3] = 32'hffff0000; dir = {dir, p};
		p = '0; p[3] = 32'h00000001; dir = {dir, p};
		p = '0; p[4] = 32'h00000001; dir = {dir, p};
		p = '0; p[4] = 32'hffffffff; dir = {dir, p};
		p = '0; p[3] = 32'hffffffff; p[4] = 32'hffffffff; p[5] = 32'hffffffff; dir = {dir, p};
		p = '0; p[3] = 32'h80000000; p[4] = 32'h00000001; dir = {dir, p};
		p = '0; p[3] = 32'h80000000; p[4] = 32'hffffffff; dir = {dir, p};
		p = '1; dir = {dir, p};
		p = '0; p[0] = 32'h12345678; p[3] = 32'h12345678; p[1] = 32'h7fffffff;
		p[4] = 32'h7fffffff; dir = {dir, p};
		p = '0; p[0] = 32'h7fffffff; p[3] = 32'h80000000; dir = {dir, p};
		foreach (dir[i]) send_pair(dir[i], 0);
		for (int n = 0; n < 2000; n++) begin
			if (n == 600) hold_req = 1;
			if (n == 1200) begin
				s_tvalid <= 0;
				while (board.pending.size() != 0) @(posedge clk);
			end
			send_pair(random_pair(), n < 600 || n > 800);
		end
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

### files.f
hdl/c2s_pkg.sv
hdl/cartesian_to_spherical_unit.sv
hdl/c2s_checker.sv
verif/tb_top.sv
